// File: rtl/bwsd_pkg.sv
// Shared types and constants for the battery window source detector.
`default_nettype none

package bwsd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 16;
   localparam int TIME_BITS   = 32;
   localparam int PCT_BITS    = 7;
   localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
   localparam int NUM_BITS    = SUM_BITS + PCT_BITS;
   localparam int PREM_BITS   = NUM_BITS + 2;
   localparam int STEP_BITS   = $clog2(SAMPLE_BITS);
   localparam int PCT_STEPS   = PCT_BITS + 1;
   localparam int PQ_IDX_BITS = $clog2(PCT_BITS);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_USB_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EMPTY_MV      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_MV       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_MS     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USB_HOLD_MS   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BATT_ABSENT   = 3'd5;

   localparam logic [SAMPLE_BITS-1:0] RST_USB_THRESHOLD = SAMPLE_BITS'(4500);
   localparam logic [SAMPLE_BITS-1:0] RST_EMPTY_MV      = SAMPLE_BITS'(3300);
   localparam logic [SAMPLE_BITS-1:0] RST_FULL_MV       = SAMPLE_BITS'(4200);
   localparam logic [TIME_BITS-1:0]   RST_WINDOW_MS     = TIME_BITS'(60000);
   localparam logic [TIME_BITS-1:0]   RST_USB_HOLD_MS   = TIME_BITS'(15000);

   localparam logic [SAMPLE_BITS-1:0] FLOOR_MV  = SAMPLE_BITS'(2500);
   localparam logic [PCT_BITS-1:0]    PCT_MAX   = PCT_BITS'(100);
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [STEP_BITS-1:0] AVG_TOP = STEP_BITS'(SAMPLE_BITS - 1);
   localparam logic [STEP_BITS-1:0] PCT_TOP = STEP_BITS'(PCT_STEPS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DECIDE,
      ST_MUL_A,
      ST_MUL_B,
      ST_AVG,
      ST_PCT_INIT,
      ST_PCT,
      ST_FINAL,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      RES_HOLD,
      RES_FRESH,
      RES_ABSENT
   } res_kind_type;

   typedef struct packed {
      logic                 load_in;
      logic                 accum;
      logic                 capture;
      logic                 mul_a;
      logic                 mul_b;
      logic                 avg_step;
      logic                 pct_init;
      logic                 pct_step;
      logic                 finish;
      logic                 set_kind;
      res_kind_type         kind;
      logic                 load_rsp;
      logic [STEP_BITS-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic close;
      logic absent;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/bwsd_ctrl.sv
// Sequencer for the battery window source detector: handshakes and step control.
`default_nettype none

module bwsd_ctrl import bwsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type            state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.step = step_ff;
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (status.absent) begin
               cmd.set_kind = 1'b1;
               cmd.kind     = RES_ABSENT;
               state_in     = ST_OUT;
            end else begin
               cmd.accum = 1'b1;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.close) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL_A;
            end else begin
               cmd.set_kind = 1'b1;
               cmd.kind     = RES_HOLD;
               state_in     = ST_OUT;
            end
         end
         ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            step_in   = AVG_TOP;
            state_in  = ST_AVG;
         end
         ST_AVG: begin
            cmd.avg_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_PCT_INIT;
            end else begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         ST_PCT_INIT: begin
            cmd.pct_init = 1'b1;
            step_in      = PCT_TOP;
            state_in     = ST_PCT;
         end
         ST_PCT: begin
            cmd.pct_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_FINAL;
            end else begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         ST_FINAL: begin
            cmd.finish   = 1'b1;
            cmd.set_kind = 1'b1;
            cmd.kind     = RES_FRESH;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/bwsd_dpath.sv
// Datapath: config registers, window accumulators, multipliers, dividers, report.
`default_nettype none

module bwsd_dpath import bwsd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic [SAMPLE_BITS-1:0]    req_sample_mv,
   input  logic [TIME_BITS-1:0]      req_now_ms,
   output logic                      rsp_on_external,
   output logic                      rsp_on_battery,
   output logic [PCT_BITS-1:0]       rsp_charge_percent,
   output logic [SAMPLE_BITS-1:0]    rsp_pack_mv,
   output logic                      rsp_refreshed,
   input  cmd_type                   cmd,
   output status_type                status
);

   // configuration
   logic [SAMPLE_BITS-1:0] thr_ff, empty_ff, full_ff;
   logic [TIME_BITS-1:0]   window_ff, hold_ff;
   logic                   absent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= RST_USB_THRESHOLD;
         empty_ff  <= RST_EMPTY_MV;
         full_ff   <= RST_FULL_MV;
         window_ff <= RST_WINDOW_MS;
         hold_ff   <= RST_USB_HOLD_MS;
         absent_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_USB_THRESHOLD: thr_ff    <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_EMPTY_MV:      empty_ff  <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_FULL_MV:       full_ff   <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_WINDOW_MS:     window_ff <= csr_wdata[TIME_BITS-1:0];
            CSR_USB_HOLD_MS:   hold_ff   <= csr_wdata[TIME_BITS-1:0];
            CSR_BATT_ABSENT:   absent_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // item capture
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [TIME_BITS-1:0]   now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         sample_ff <= req_sample_mv;
         now_ff    <= req_now_ms;
      end
   end

   // window
   logic [TIME_BITS-1:0]   start_ff;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SAMPLE_BITS-1:0] peak_ff;
   logic [COUNT_BITS-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         sum_ff   <= '0;
         peak_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.accum) begin
         if (count_ff == '0) begin
            start_ff <= now_ff;
            peak_ff  <= sample_ff;
         end else if (sample_ff > peak_ff) begin
            peak_ff <= sample_ff;
         end
         sum_ff   <= sum_ff + SUM_BITS'(sample_ff);
         count_ff <= count_ff + COUNT_BITS'(1);
      end else if (cmd.capture) begin
         sum_ff   <= '0;
         peak_ff  <= '0;
         count_ff <= '0;
      end
   end

   // report state
   logic                   rep_ext_ff, rep_present_ff, rep_valid_ff;
   logic [PCT_BITS-1:0]    rep_pct_ff;
   logic [SAMPLE_BITS-1:0] rep_mv_ff;

   // close decision
   logic                 saw;
   logic [TIME_BITS-1:0] elapsed, hold_sel;

   always_comb begin
      saw           = (peak_ff >= thr_ff);
      elapsed       = now_ff - start_ff;
      hold_sel      = rep_ext_ff ? hold_ff : window_ff;
      status.close  = !rep_valid_ff || (saw && !rep_ext_ff) || (elapsed >= hold_sel)
                      || (count_ff >= COUNT_MAX);
      status.absent = absent_ff;
   end

   // closed window arithmetic
   logic [SUM_BITS-1:0]    sum_q;
   logic [COUNT_BITS-1:0]  cnt_q;
   logic                   saw_q;
   logic [SUM_BITS-1:0]    base_ff, den_ff;
   logic                   span_ok_ff, pct_ok_ff;
   logic [NUM_BITS-1:0]    num_ff;
   logic [SUM_BITS-1:0]    rem_a_ff;
   logic [SAMPLE_BITS-1:0] avg_ff;
   logic [PREM_BITS-1:0]   rem_p_ff;
   logic [PCT_BITS-1:0]    pq_ff;
   logic                   ovf_ff;
   logic [SAMPLE_BITS-1:0] span;
   logic [SUM_BITS-1:0]    dsh_a;
   logic [PREM_BITS-1:0]   dsh_p;

   assign span  = full_ff - empty_ff;
   assign dsh_a = SUM_BITS'(cnt_q) << cmd.step;
   assign dsh_p = PREM_BITS'({den_ff, 1'b0}) << cmd.step;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sum_q <= sum_ff;
         cnt_q <= count_ff;
         saw_q <= saw;
      end
      if (cmd.mul_a) begin
         base_ff    <= SUM_BITS'(empty_ff) * SUM_BITS'(cnt_q);
         den_ff     <= (full_ff > empty_ff) ? SUM_BITS'(span) * SUM_BITS'(cnt_q) : '0;
         span_ok_ff <= (full_ff > empty_ff);
         rem_a_ff   <= sum_q;
         avg_ff     <= '0;
      end
      if (cmd.mul_b) begin
         pct_ok_ff <= span_ok_ff && (sum_q > base_ff);
         num_ff    <= NUM_BITS'(sum_q - base_ff) * NUM_BITS'(PCT_MAX);
      end
      if (cmd.avg_step) begin
         if (rem_a_ff >= dsh_a) begin
            rem_a_ff          <= rem_a_ff - dsh_a;
            avg_ff[cmd.step]  <= 1'b1;
         end
      end
      if (cmd.pct_init) begin
         rem_p_ff <= PREM_BITS'({num_ff, 1'b0}) + PREM_BITS'(den_ff);
         pq_ff    <= '0;
         ovf_ff   <= 1'b0;
      end
      if (cmd.pct_step) begin
         // top step only detects a quotient beyond the percent range
         if (cmd.step == PCT_TOP) begin
            ovf_ff <= (rem_p_ff >= dsh_p);
         end else if (rem_p_ff >= dsh_p) begin
            rem_p_ff                        <= rem_p_ff - dsh_p;
            pq_ff[cmd.step[PQ_IDX_BITS-1:0]] <= 1'b1;
         end
      end
   end

   logic [PCT_BITS-1:0] pct_val;
   logic                go_ext;

   always_comb begin
      if (!pct_ok_ff) begin
         pct_val = '0;
      end else if (ovf_ff || (pq_ff > PCT_MAX)) begin
         pct_val = PCT_MAX;
      end else begin
         pct_val = pq_ff;
      end
      go_ext = saw_q || (avg_ff < FLOOR_MV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_ext_ff     <= 1'b0;
         rep_present_ff <= 1'b0;
         rep_pct_ff     <= '0;
         rep_mv_ff      <= '0;
         rep_valid_ff   <= 1'b0;
      end else if (cmd.finish) begin
         rep_valid_ff <= 1'b1;
         if (go_ext) begin
            rep_ext_ff     <= 1'b1;
            rep_present_ff <= 1'b0;
            rep_pct_ff     <= '0;
            rep_mv_ff      <= '0;
         end else begin
            rep_ext_ff     <= 1'b0;
            rep_present_ff <= 1'b1;
            rep_pct_ff     <= pct_val;
            rep_mv_ff      <= avg_ff;
         end
      end
   end

   // result register
   res_kind_type kind_ff;

   always_ff @(posedge clock) begin
      if (cmd.set_kind) begin
         kind_ff <= cmd.kind;
      end
      if (cmd.load_rsp) begin
         case (kind_ff)
            RES_ABSENT: begin
               rsp_on_external    <= 1'b1;
               rsp_on_battery     <= 1'b0;
               rsp_charge_percent <= '0;
               rsp_pack_mv        <= '0;
               rsp_refreshed      <= 1'b0;
            end
            RES_FRESH: begin
               rsp_on_external    <= rep_ext_ff;
               rsp_on_battery     <= rep_present_ff;
               rsp_charge_percent <= rep_pct_ff;
               rsp_pack_mv        <= rep_mv_ff;
               rsp_refreshed      <= 1'b1;
            end
            default: begin
               rsp_on_external    <= rep_ext_ff;
               rsp_on_battery     <= rep_present_ff;
               rsp_charge_percent <= rep_pct_ff;
               rsp_pack_mv        <= rep_mv_ff;
               rsp_refreshed      <= 1'b0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/battery_window_source_detector.sv
// Top level of the battery window source detector.
// Each accepted poll (sample_mv, now_ms) yields exactly one result. A poll that
// leaves the window open passes the accumulate, decide and output steps; with
// battery_absent set, accumulate goes straight to output. A poll that closes the
// window adds the multiply steps MUL_A and MUL_B, a 16-step restoring divider for
// the window average and an 8-step divider for the rounded percent, run one after
// the other on the same sequencer. The result sits in an output register, so the
// next poll can be accepted while it waits for rsp_ready; a poll that reaches its
// output step while that register holds an untaken result stalls until rsp_ready.
// Configuration is to be written only while the block is idle; not enforced here.
`default_nettype none

module battery_window_source_detector import bwsd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_sample_mv,
   input  logic [TIME_BITS-1:0]      req_now_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_on_external,
   output logic                      rsp_on_battery,
   output logic [PCT_BITS-1:0]       rsp_charge_percent,
   output logic [SAMPLE_BITS-1:0]    rsp_pack_mv,
   output logic                      rsp_refreshed,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bwsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bwsd_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_sample_mv      (req_sample_mv),
      .req_now_ms         (req_now_ms),
      .rsp_on_external    (rsp_on_external),
      .rsp_on_battery     (rsp_on_battery),
      .rsp_charge_percent (rsp_charge_percent),
      .rsp_pack_mv        (rsp_pack_mv),
      .rsp_refreshed      (rsp_refreshed),
      .cmd                (cmd),
      .status             (status)
   );

`ifndef NO_ASSERTIONS
   a_source_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_on_external && rsp_on_battery))
      else $error("result reports both sources");

   a_external_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_on_battery) |-> (rsp_charge_percent == '0 && rsp_pack_mv == '0))
      else $error("percent or voltage set without battery");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_charge_percent <= PCT_MAX))
      else $error("percent above range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while an item is in work");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten before taken");
`endif

endmodule

`default_nettype wire
